### design/eps_pkg.sv
`default_nettype none
package eps_pkg;

    localparam int FIELD_W = 16;
    localparam int SLOT_W  = 4;
    localparam int REM_W   = 16;
    localparam int DL_W    = 16;
    localparam int CFG_W   = 5;
    localparam int KIND_W  = 2;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_STEP = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_RUN  = 2'd0,
        KIND_IDLE = 2'd1,
        KIND_NONE = 2'd2,
        KIND_LOAD = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PRIME,
        ST_SCAN,
        ST_FETCH,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic take_min;
        logic take_sel;
        logic take_next;
    } t_cmp;

endpackage
`default_nettype wire

### design/eps_table.sv
`default_nettype none
module eps_table #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 16,
    localparam int IDX_W = $clog2(MAX_TASKS)
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_we,
    input  wire logic [IDX_W-1:0]         i_waddr,
    input  wire logic [TIME_BITS-1:0]     i_wid,
    input  wire logic [TIME_BITS-1:0]     i_warr,
    input  wire logic [eps_pkg::REM_W-1:0] i_wrem,
    input  wire logic [eps_pkg::DL_W-1:0] i_wdl,
    input  wire logic                     i_wstarted,
    input  wire logic [IDX_W-1:0]         i_raddr,
    output logic [TIME_BITS-1:0]          o_rid,
    output logic [TIME_BITS-1:0]          o_rarr,
    output logic [eps_pkg::REM_W-1:0]     o_rrem,
    output logic [eps_pkg::DL_W-1:0]      o_rdl,
    output logic                          o_rstarted
);
    import eps_pkg::*;

    localparam int ROW_W = 2 * TIME_BITS + REM_W + DL_W;

    logic [ROW_W-1:0]     r_mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] r_valid;
    logic [MAX_TASKS-1:0] r_started;
    logic [ROW_W-1:0]     r_rd_row;
    logic                 r_rd_valid;
    logic                 r_rd_started;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wid, i_warr, i_wrem, i_wdl};
        end
        r_rd_row     <= r_mem[i_raddr];
        r_rd_valid   <= r_valid[i_raddr];
        r_rd_started <= r_started[i_raddr];
    end

    // remaining and started flags reset to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid   <= '0;
            r_started <= '0;
        end else if (i_we) begin
            r_valid[i_waddr]   <= 1'b1;
            r_started[i_waddr] <= i_wstarted;
        end
    end

    assign o_rid      = r_rd_row[ROW_W-1 -: TIME_BITS];
    assign o_rarr     = r_rd_row[ROW_W-TIME_BITS-1 -: TIME_BITS];
    assign o_rrem     = r_rd_valid ? r_rd_row[DL_W +: REM_W] : '0;
    assign o_rdl      = r_rd_row[DL_W-1:0];
    assign o_rstarted = r_rd_valid & r_rd_started;

endmodule
`default_nettype wire

### design/eps_cmp.sv
`default_nettype none
module eps_cmp #(
    parameter int TIME_BITS = 16
) (
    input  wire logic                     i_first,
    input  wire logic [TIME_BITS-1:0]     i_arr,
    input  wire logic                     i_rem_nz,
    input  wire logic [eps_pkg::DL_W-1:0] i_dl,
    input  wire logic [TIME_BITS-1:0]     i_clock,
    input  wire logic [TIME_BITS-1:0]     i_min,
    input  wire logic                     i_sel_found,
    input  wire logic [eps_pkg::DL_W-1:0] i_sel_dl,
    input  wire logic                     i_nxt_found,
    input  wire logic [TIME_BITS-1:0]     i_nxt_arr,
    output eps_pkg::t_cmp                 o_cmp
);
    import eps_pkg::*;

    logic arrived;

    always_comb begin
        arrived          = (i_arr <= i_clock);
        o_cmp.take_min   = i_first || (i_arr < i_min);
        // earliest deadline, lowest slot on a tie
        o_cmp.take_sel   = i_rem_nz && arrived && (!i_sel_found || (i_dl < i_sel_dl));
        o_cmp.take_next  = i_rem_nz && !arrived && (!i_nxt_found || (i_arr < i_nxt_arr));
    end

endmodule
`default_nettype wire

### design/edf_preemptive_scheduler_top.sv
`default_nettype none
// load, or a step once every task is done: result registered in the cycle after the start beat
// step: the first step of a schedule runs a clock priming pass, then a selection pass
// over N slots; later steps run the selection pass only; a run answer then passes
// the fetch and execute states, an idle or nothing-left answer skips them; one table row read per cycle
// result strobe lasts one cycle, the receiver cannot stall
// synchronous active-low reset clears control state, remaining and started flags
module edf_preemptive_scheduler_top #(
    parameter int MAX_TASKS = 16,
    parameter int TIME_BITS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic                        i_req_type,
    input  wire logic [eps_pkg::SLOT_W-1:0]  i_slot,
    input  wire logic [eps_pkg::FIELD_W-1:0] i_task_id,
    input  wire logic [eps_pkg::FIELD_W-1:0] i_arrival,
    input  wire logic [eps_pkg::FIELD_W-1:0] i_burst,
    input  wire logic [eps_pkg::FIELD_W-1:0] i_deadline,
    input  wire logic                        i_cfg_we,
    input  wire logic [eps_pkg::CFG_W-1:0]   i_cfg_wdata,
    output logic                             o_strobe,
    output logic [eps_pkg::KIND_W-1:0]       o_kind,
    output logic [eps_pkg::FIELD_W-1:0]      o_run_id,
    output logic [eps_pkg::FIELD_W-1:0]      o_span_start,
    output logic [eps_pkg::FIELD_W-1:0]      o_span_end,
    output logic                             o_extends_previous,
    output logic                             o_response_valid,
    output logic [eps_pkg::FIELD_W-1:0]      o_resp_delay,
    output logic                             o_finished,
    output logic [eps_pkg::FIELD_W-1:0]      o_finish_at,
    output logic                             o_all_done
);
    import eps_pkg::*;

    localparam int IDX_W = $clog2(MAX_TASKS);
    localparam int CNT_W = $clog2(MAX_TASKS + 1);

    t_state               r_state, n_state;
    logic [CFG_W-1:0]     r_task_count;
    logic [CNT_W-1:0]     r_idx, n_idx;
    logic [TIME_BITS-1:0] r_clock, n_clock;
    logic                 r_primed, n_primed;
    logic [CNT_W-1:0]     r_done, n_done;
    logic [TIME_BITS-1:0] r_last_id, n_last_id;
    logic                 r_last_valid, n_last_valid;
    logic [TIME_BITS-1:0] r_min, n_min;
    logic                 r_sel_found, n_sel_found;
    logic [IDX_W-1:0]     r_sel_idx, n_sel_idx;
    logic [DL_W-1:0]      r_sel_dl, n_sel_dl;
    logic                 r_nxt_found, n_nxt_found;
    logic [TIME_BITS-1:0] r_nxt_arr, n_nxt_arr;

    logic                 r_strobe, n_strobe;
    t_kind                r_kind, n_kind;
    logic [FIELD_W-1:0]   r_run_id, n_run_id;
    logic [FIELD_W-1:0]   r_span_start, n_span_start;
    logic [FIELD_W-1:0]   r_span_end, n_span_end;
    logic                 r_ext, n_ext;
    logic                 r_resp_valid, n_resp_valid;
    logic [FIELD_W-1:0]   r_resp_time, n_resp_time;
    logic                 r_finished, n_finished;
    logic [FIELD_W-1:0]   r_compl_time, n_compl_time;
    logic                 r_all_done, n_all_done;

    logic                 accept;
    logic                 slot_ok;
    logic [CNT_W-1:0]     n_act;
    logic [CNT_W-1:0]     proc_cnt;
    logic [IDX_W-1:0]     rd_addr;
    logic [REM_W-1:0]     rem_dec;

    logic                 tbl_we;
    logic [IDX_W-1:0]     tbl_waddr;
    logic [TIME_BITS-1:0] tbl_wid;
    logic [TIME_BITS-1:0] tbl_warr;
    logic [REM_W-1:0]     tbl_wrem;
    logic [DL_W-1:0]      tbl_wdl;
    logic                 tbl_wstarted;

    logic [TIME_BITS-1:0] rd_id;
    logic [TIME_BITS-1:0] rd_arr;
    logic [REM_W-1:0]     rd_rem;
    logic [DL_W-1:0]      rd_dl;
    logic                 rd_started;
    t_cmp                 cmp;

    assign busy    = (r_state != ST_IDLE);
    assign accept  = start && !busy;
    assign slot_ok = (32'(i_slot) < MAX_TASKS);

    always_comb begin
        if (r_task_count == '0) begin
            n_act = CNT_W'(1);
        end else if (32'(r_task_count) > MAX_TASKS) begin
            n_act = CNT_W'(MAX_TASKS);
        end else begin
            n_act = CNT_W'(r_task_count);
        end
    end

    assign proc_cnt = r_idx - CNT_W'(1);
    assign rem_dec  = rd_rem - REM_W'(1);

    always_comb begin
        if (r_state == ST_FETCH) begin
            rd_addr = r_sel_idx;
        end else if (r_idx < n_act) begin
            rd_addr = r_idx[IDX_W-1:0];
        end else begin
            rd_addr = '0;
        end
    end

    always_comb begin
        if (r_state == ST_EXEC) begin
            tbl_we       = 1'b1;
            tbl_waddr    = r_sel_idx;
            tbl_wid      = rd_id;
            tbl_warr     = rd_arr;
            tbl_wrem     = rem_dec;
            tbl_wdl      = rd_dl;
            tbl_wstarted = 1'b1;
        end else begin
            tbl_we       = accept && (i_req_type == REQ_LOAD) && slot_ok;
            tbl_waddr    = IDX_W'(i_slot);
            tbl_wid      = TIME_BITS'(i_task_id);
            tbl_warr     = TIME_BITS'(i_arrival);
            tbl_wrem     = i_burst;
            tbl_wdl      = i_deadline;
            tbl_wstarted = 1'b0;
        end
    end

    eps_table #(
        .MAX_TASKS (MAX_TASKS),
        .TIME_BITS (TIME_BITS)
    ) u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (tbl_we),
        .i_waddr    (tbl_waddr),
        .i_wid      (tbl_wid),
        .i_warr     (tbl_warr),
        .i_wrem     (tbl_wrem),
        .i_wdl      (tbl_wdl),
        .i_wstarted (tbl_wstarted),
        .i_raddr    (rd_addr),
        .o_rid      (rd_id),
        .o_rarr     (rd_arr),
        .o_rrem     (rd_rem),
        .o_rdl      (rd_dl),
        .o_rstarted (rd_started)
    );

    eps_cmp #(
        .TIME_BITS (TIME_BITS)
    ) u_cmp (
        .i_first     (r_idx == CNT_W'(1)),
        .i_arr       (rd_arr),
        .i_rem_nz    (rd_rem != '0),
        .i_dl        (rd_dl),
        .i_clock     (r_clock),
        .i_min       (r_min),
        .i_sel_found (r_sel_found),
        .i_sel_dl    (r_sel_dl),
        .i_nxt_found (r_nxt_found),
        .i_nxt_arr   (r_nxt_arr),
        .o_cmp       (cmp)
    );

    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_clock      = r_clock;
        n_primed     = r_primed;
        n_done       = r_done;
        n_last_id    = r_last_id;
        n_last_valid = r_last_valid;
        n_min        = r_min;
        n_sel_found  = r_sel_found;
        n_sel_idx    = r_sel_idx;
        n_sel_dl     = r_sel_dl;
        n_nxt_found  = r_nxt_found;
        n_nxt_arr    = r_nxt_arr;
        n_strobe     = 1'b0;
        n_kind       = KIND_LOAD;
        n_run_id     = '0;
        n_span_start = '0;
        n_span_end   = '0;
        n_ext        = 1'b0;
        n_resp_valid = 1'b0;
        n_resp_time  = '0;
        n_finished   = 1'b0;
        n_compl_time = '0;
        n_all_done   = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (i_req_type == REQ_LOAD) begin
                        // a load starts a new schedule
                        n_primed     = 1'b0;
                        n_done       = '0;
                        n_last_valid = 1'b0;
                        n_strobe     = 1'b1;
                        n_kind       = KIND_LOAD;
                    end else if (r_done >= n_act) begin
                        n_strobe   = 1'b1;
                        n_kind     = KIND_NONE;
                        n_all_done = 1'b1;
                    end else begin
                        n_idx       = '0;
                        n_sel_found = 1'b0;
                        n_nxt_found = 1'b0;
                        n_state     = r_primed ? ST_SCAN : ST_PRIME;
                    end
                end
            end
            ST_PRIME: begin
                if (r_idx != '0 && cmp.take_min) begin
                    n_min = rd_arr;
                end
                if (r_idx == n_act) begin
                    n_clock  = n_min;
                    n_primed = 1'b1;
                    n_idx    = '0;
                    n_state  = ST_SCAN;
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            ST_SCAN: begin
                if (r_idx != '0) begin
                    if (cmp.take_sel) begin
                        n_sel_found = 1'b1;
                        n_sel_idx   = proc_cnt[IDX_W-1:0];
                        n_sel_dl    = rd_dl;
                    end
                    if (cmp.take_next) begin
                        n_nxt_found = 1'b1;
                        n_nxt_arr   = rd_arr;
                    end
                end
                if (r_idx == n_act) begin
                    if (n_sel_found) begin
                        n_state = ST_FETCH;
                    end else if (n_nxt_found) begin
                        // idle span up to the next arrival
                        n_strobe     = 1'b1;
                        n_kind       = KIND_IDLE;
                        n_span_start = FIELD_W'(r_clock);
                        n_span_end   = FIELD_W'(n_nxt_arr);
                        n_clock      = n_nxt_arr;
                        n_last_valid = 1'b0;
                        n_state      = ST_IDLE;
                    end else begin
                        n_strobe   = 1'b1;
                        n_kind     = KIND_NONE;
                        n_all_done = (r_done >= n_act);
                        n_state    = ST_IDLE;
                    end
                end else begin
                    n_idx = r_idx + CNT_W'(1);
                end
            end
            ST_FETCH: begin
                n_state = ST_EXEC;
            end
            ST_EXEC: begin
                n_clock = (r_clock == '1) ? r_clock : r_clock + TIME_BITS'(1);
                n_strobe     = 1'b1;
                n_kind       = KIND_RUN;
                n_run_id     = FIELD_W'(rd_id);
                n_span_start = FIELD_W'(r_clock);
                n_span_end   = FIELD_W'(n_clock);
                n_ext        = r_last_valid && (r_last_id == rd_id);
                if (!rd_started) begin
                    n_resp_valid = 1'b1;
                    n_resp_time  = FIELD_W'(r_clock - rd_arr);
                end
                if (rem_dec == '0) begin
                    n_finished   = 1'b1;
                    n_compl_time = FIELD_W'(n_clock);
                    if (r_done < n_act) begin
                        n_done = r_done + CNT_W'(1);
                    end
                end
                n_all_done   = (n_done >= n_act);
                n_last_id    = rd_id;
                n_last_valid = 1'b1;
                n_state      = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_task_count <= CFG_W'(1);
            r_idx        <= '0;
            r_clock      <= '0;
            r_primed     <= 1'b0;
            r_done       <= '0;
            r_last_id    <= '0;
            r_last_valid <= 1'b0;
            r_sel_found  <= 1'b0;
            r_nxt_found  <= 1'b0;
            r_strobe     <= 1'b0;
        end else begin
            r_state      <= n_state;
            if (i_cfg_we) begin
                r_task_count <= i_cfg_wdata;
            end
            r_idx        <= n_idx;
            r_clock      <= n_clock;
            r_primed     <= n_primed;
            r_done       <= n_done;
            r_last_id    <= n_last_id;
            r_last_valid <= n_last_valid;
            r_sel_found  <= n_sel_found;
            r_nxt_found  <= n_nxt_found;
            r_strobe     <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_min        <= n_min;
        r_sel_idx    <= n_sel_idx;
        r_sel_dl     <= n_sel_dl;
        r_nxt_arr    <= n_nxt_arr;
        r_kind       <= n_kind;
        r_run_id     <= n_run_id;
        r_span_start <= n_span_start;
        r_span_end   <= n_span_end;
        r_ext        <= n_ext;
        r_resp_valid <= n_resp_valid;
        r_resp_time  <= n_resp_time;
        r_finished   <= n_finished;
        r_compl_time <= n_compl_time;
        r_all_done   <= n_all_done;
    end

    assign o_strobe           = r_strobe;
    assign o_kind             = r_kind;
    assign o_run_id           = r_run_id;
    assign o_span_start       = r_span_start;
    assign o_span_end         = r_span_end;
    assign o_extends_previous = r_ext;
    assign o_response_valid   = r_resp_valid;
    assign o_resp_delay       = r_resp_time;
    assign o_finished         = r_finished;
    assign o_finish_at        = r_compl_time;
    assign o_all_done         = r_all_done;

    // every beat closes the item and returns the block to idle
    a_beat_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> !busy)
        else $error("result beat while busy");

    a_beat_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(busy) || $past(start)))
        else $error("result beat without an item");

    a_done_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_done) <= MAX_TASKS)
        else $error("done count beyond table size");

    a_all_done_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_all_done) |-> (r_kind == KIND_RUN || r_kind == KIND_NONE))
        else $error("all done flagged on load or idle beat");

endmodule
`default_nettype wire

### bench/tb_edf_preemptive_scheduler_top.sv
`timescale 1ns / 100ps
module tb_edf_preemptive_scheduler_top;
    import eps_pkg::*;

    localparam int STALL_LIMIT = 1000;
    localparam int ITEM_TARGET = 550;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic        i_req_type = REQ_LOAD;
    logic [3:0]  i_slot = '0;
    logic [15:0] i_task_id = '0;
    logic [15:0] i_arrival = '0;
    logic [15:0] i_burst = '0;
    logic [15:0] i_deadline = '0;
    logic        i_cfg_we = 1'b0;
    logic [4:0]  i_cfg_wdata = '0;
    logic        o_strobe;
    logic [1:0]  o_kind;
    logic [15:0] o_run_id;
    logic [15:0] o_span_start;
    logic [15:0] o_span_end;
    logic        o_extends_previous;
    logic        o_response_valid;
    logic [15:0] o_resp_delay;
    logic        o_finished;
    logic [15:0] o_finish_at;
    logic        o_all_done;

    typedef struct packed {
        logic        req;
        logic [3:0]  slot;
        logic [15:0] task_id;
        logic [15:0] arrival;
        logic [15:0] burst;
        logic [15:0] deadline;
    } sched_req_t;

    typedef struct packed {
        t_kind       kind;
        logic [15:0] run_id;
        logic [15:0] span_start;
        logic [15:0] span_end;
        logic        ext;
        logic        resp_valid;
        logic [15:0] resp_time;
        logic        fin;
        logic [15:0] comp_time;
        logic        all_done;
    } decision_t;

    class edf_decision_board;
        logic [15:0] tbl_id[16];
        logic [15:0] tbl_arr[16];
        logic [15:0] tbl_left[16];
        logic [15:0] tbl_dl[16];
        bit          tbl_begun[16];
        logic [15:0] now_t;
        bit          now_set;
        int          n_done;
        logic [15:0] prev_id;
        bit          prev_ok;
        logic [4:0]  slots_cfg;
        decision_t   pending[$];
        int          errors;

        function new();
            for (int i = 0; i < 16; i++) begin
                tbl_id[i] = '0;
                tbl_arr[i] = '0;
                tbl_left[i] = '0;
                tbl_dl[i] = '0;
                tbl_begun[i] = 1'b0;
            end
            now_t = '0;
            now_set = 1'b0;
            n_done = 0;
            prev_id = '0;
            prev_ok = 1'b0;
            slots_cfg = 5'd1;
            errors = 0;
        endfunction

        function void set_count(logic [4:0] v);
            slots_cfg = v;
        endfunction

        function void note_request(sched_req_t r);
            decision_t   d;
            int          n;
            int          sel;
            bit          have_next;
            logic [15:0] next_arr;
            d = '0;
            n = (slots_cfg == 0) ? 1 : ((slots_cfg > 16) ? 16 : int'(slots_cfg));
            if (r.req == REQ_LOAD) begin
                tbl_id[r.slot] = r.task_id;
                tbl_arr[r.slot] = r.arrival;
                tbl_left[r.slot] = r.burst;
                tbl_dl[r.slot] = r.deadline;
                tbl_begun[r.slot] = 1'b0;
                now_set = 1'b0;
                n_done = 0;
                prev_ok = 1'b0;
                d.kind = KIND_LOAD;
            end else if (n_done >= n) begin
                d.kind = KIND_NONE;
                d.all_done = 1'b1;
            end else begin
                if (!now_set) begin
                    now_t = tbl_arr[0];
                    for (int i = 1; i < n; i++)
                        if (tbl_arr[i] < now_t) now_t = tbl_arr[i];
                    now_set = 1'b1;
                end
                sel = -1;
                for (int i = 0; i < n; i++) begin
                    if (tbl_left[i] != 0 && tbl_arr[i] <= now_t) begin
                        if (sel < 0 || tbl_dl[i] < tbl_dl[sel]) sel = i;
                    end
                end
                if (sel < 0) begin
                    have_next = 1'b0;
                    next_arr = '0;
                    for (int i = 0; i < n; i++) begin
                        if (tbl_left[i] != 0 && tbl_arr[i] > now_t) begin
                            if (!have_next || tbl_arr[i] < next_arr) begin
                                next_arr = tbl_arr[i];
                                have_next = 1'b1;
                            end
                        end
                    end
                    if (!have_next) begin
                        d.kind = KIND_NONE;
                        d.all_done = (n_done >= n);
                    end else begin
                        d.kind = KIND_IDLE;
                        d.span_start = now_t;
                        d.span_end = next_arr;
                        now_t = next_arr;
                        prev_ok = 1'b0;
                    end
                end else begin
                    d.kind = KIND_RUN;
                    d.run_id = tbl_id[sel];
                    d.span_start = now_t;
                    d.ext = prev_ok && (prev_id == tbl_id[sel]);
                    if (!tbl_begun[sel]) begin
                        tbl_begun[sel] = 1'b1;
                        d.resp_valid = 1'b1;
                        d.resp_time = now_t - tbl_arr[sel];
                    end
                    tbl_left[sel] = tbl_left[sel] - 16'd1;
                    if (now_t != 16'hFFFF) now_t = now_t + 16'd1;
                    d.span_end = now_t;
                    if (tbl_left[sel] == 0) begin
                        d.fin = 1'b1;
                        d.comp_time = now_t;
                        if (n_done < n) n_done++;
                    end
                    d.all_done = (n_done >= n);
                    prev_id = tbl_id[sel];
                    prev_ok = 1'b1;
                end
            end
            pending.push_back(d);
        endfunction

        task report_mismatch(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors++;
        endtask

        task compare_field(string name, logic [15:0] got, logic [15:0] want);
            if (got !== want)
                report_mismatch($sformatf("%s got %h want %h", name, got, want));
        endtask

        task check_decision(decision_t got);
            decision_t want;
            if (pending.size() == 0) begin
                report_mismatch("result beat with no request outstanding");
                return;
            end
            want = pending.pop_front();
            compare_field("kind", 16'(got.kind), 16'(want.kind));
            compare_field("run_id", got.run_id, want.run_id);
            compare_field("span_start", got.span_start, want.span_start);
            compare_field("span_end", got.span_end, want.span_end);
            compare_field("extends_previous", 16'(got.ext), 16'(want.ext));
            compare_field("response_valid", 16'(got.resp_valid), 16'(want.resp_valid));
            compare_field("resp_delay", got.resp_time, want.resp_time);
            compare_field("finished", 16'(got.fin), 16'(want.fin));
            compare_field("finish_at", got.comp_time, want.comp_time);
            compare_field("all_done", 16'(got.all_done), 16'(want.all_done));
        endtask
    endclass

    edf_decision_board board;
    decision_t         seen;
    int                sent = 0;
    int                idle_cycles = 0;

    edf_preemptive_scheduler_top uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_req_type         (i_req_type),
        .i_slot             (i_slot),
        .i_task_id          (i_task_id),
        .i_arrival          (i_arrival),
        .i_burst            (i_burst),
        .i_deadline         (i_deadline),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_strobe           (o_strobe),
        .o_kind             (o_kind),
        .o_run_id           (o_run_id),
        .o_span_start       (o_span_start),
        .o_span_end         (o_span_end),
        .o_extends_previous (o_extends_previous),
        .o_response_valid   (o_response_valid),
        .o_resp_delay       (o_resp_delay),
        .o_finished         (o_finished),
        .o_finish_at        (o_finish_at),
        .o_all_done         (o_all_done)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe === 1'b1) begin
            seen.kind = t_kind'(o_kind);
            seen.run_id = o_run_id;
            seen.span_start = o_span_start;
            seen.span_end = o_span_end;
            seen.ext = o_extends_previous;
            seen.resp_valid = o_response_valid;
            seen.resp_time = o_resp_delay;
            seen.fin = o_finished;
            seen.comp_time = o_finish_at;
            seen.all_done = o_all_done;
            board.check_decision(seen);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_strobe === 1'b1) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("edf_preemptive_scheduler_top verification failed");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic send(sched_req_t r);
        start <= 1'b1;
        i_req_type <= r.req;
        i_slot <= r.slot;
        i_task_id <= r.task_id;
        i_arrival <= r.arrival;
        i_burst <= r.burst;
        i_deadline <= r.deadline;
        do @(posedge i_clk); while (busy !== 1'b0);
        board.note_request(r);
        sent++;
    endtask

    task automatic pause(int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic gap(bit quiet);
        int p;
        p = $urandom_range(0, 99);
        if (!quiet && p >= 60) begin
            if (p < 92) pause($urandom_range(1, 3));
            else pause($urandom_range(8, 40));
        end
    endtask

    task automatic config_write(logic [4:0] v);
        start <= 1'b0;
        while (board.pending.size() != 0 || busy !== 1'b0) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        board.set_count(v);
    endtask

    function automatic sched_req_t mk_load(int s, int id, int arr, int bur, int dl);
        sched_req_t r;
        r.req = REQ_LOAD;
        r.slot = s[3:0];
        r.task_id = id[15:0];
        r.arrival = arr[15:0];
        r.burst = bur[15:0];
        r.deadline = dl[15:0];
        return r;
    endfunction

    function automatic sched_req_t mk_step();
        sched_req_t r;
        r.req = REQ_STEP;
        r.slot = 4'($urandom);
        r.task_id = 16'($urandom);
        r.arrival = 16'($urandom);
        r.burst = 16'($urandom);
        r.deadline = 16'($urandom);
        return r;
    endfunction

    task automatic load_random(input int s, input int ba, input int bd, output int b);
        sched_req_t r;
        int         p;
        int         arr;
        r.req = REQ_LOAD;
        r.slot = s[3:0];
        if ($urandom_range(0, 1) == 1) r.task_id = 16'($urandom_range(0, 3));
        else r.task_id = 16'($urandom);
        arr = ba + $urandom_range(0, 30);
        r.arrival = (arr > 65535) ? 16'hFFFF : arr[15:0];
        p = $urandom_range(0, 99);
        if (p < 85) r.burst = 16'($urandom_range(1, 5));
        else if (p < 95) r.burst = 16'($urandom_range(6, 20));
        else if (p < 98) r.burst = 16'($urandom_range(1, 65535));
        else r.burst = '0;
        if ($urandom_range(0, 1) == 1) r.deadline = 16'(bd + $urandom_range(0, 10));
        else r.deadline = 16'($urandom_range(0, 65534));
        b = int'(r.burst);
        send(r);
    endtask

    task automatic run_phase();
        int         p;
        int         n;
        int         steps;
        int         total;
        int         b;
        int         k;
        int         tmp;
        int         base_arr;
        int         base_dl;
        int         order[16];
        logic [4:0] cfg;
        bit         quiet;
        p = $urandom_range(0, 9);
        case (p)
            0: cfg = 5'd0;
            1: cfg = 5'd31;
            2: cfg = 5'd16;
            3: cfg = 5'd1;
            4: cfg = 5'($urandom_range(17, 30));
            default: cfg = 5'($urandom_range(2, 15));
        endcase
        n = (cfg == 0) ? 1 : ((cfg > 16) ? 16 : int'(cfg));
        quiet = ($urandom_range(0, 3) == 0);
        config_write(cfg);
        p = $urandom_range(0, 9);
        if (p < 7) base_arr = $urandom_range(0, 200);
        else if (p < 9) base_arr = $urandom_range(0, 65535);
        else base_arr = $urandom_range(65500, 65535);
        base_dl = $urandom_range(0, 65000);
        for (int j = 0; j < 16; j++) order[j] = j;
        for (int j = n - 1; j > 0; j--) begin
            k = $urandom_range(0, j);
            tmp = order[j];
            order[j] = order[k];
            order[k] = tmp;
        end
        total = 0;
        for (int j = 0; j < n; j++) begin
            load_random(order[j], base_arr, base_dl, b);
            total += b;
            gap(quiet);
        end
        // slots past the active count
        if (n < 16 && $urandom_range(0, 4) == 0) begin
            load_random($urandom_range(n, 15), base_arr, base_dl, b);
            gap(quiet);
        end
        steps = total + n + $urandom_range(1, 3);
        if (steps > 45) steps = 45;
        for (int j = 0; j < steps; j++) begin
            // reload mid-schedule
            if ($urandom_range(0, 24) == 0) begin
                load_random($urandom_range(0, n - 1), base_arr, base_dl, b);
                gap(quiet);
            end
            send(mk_step());
            gap(quiet);
        end
    endtask

    initial begin
        board = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // saturation at the top of the time range
        send(mk_load(0, 16'hFFFF, 65533, 4, 65534));
        repeat (5) send(mk_step());

        // zero burst with count zero
        config_write(5'd0);
        send(mk_load(0, 0, 16'hFFFF, 0, 0));
        send(mk_step());

        // deadline tie, shared id, idle span, reload mid-schedule
        config_write(5'd3);
        send(mk_load(0, 5, 10, 2, 50));
        send(mk_load(1, 5, 10, 1, 50));
        send(mk_load(2, 7, 20, 65535, 0));
        repeat (5) send(mk_step());
        send(mk_load(1, 16'h8000, 0, 1, 65534));
        send(mk_step());

        while (sent < ITEM_TARGET) run_phase();

        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("edf_preemptive_scheduler_top verification clean");
        end else begin
            $display("edf_preemptive_scheduler_top verification failed");
        end
        $finish;
    end

endmodule

### edf_preemptive_scheduler_top.f
design/eps_pkg.sv
design/eps_table.sv
design/eps_cmp.sv
design/edf_preemptive_scheduler_top.sv
bench/tb_edf_preemptive_scheduler_top.sv
